// ===== rtl/core/fcce_pkg.sv =====
package fcce_pkg;

    // payload field widths
    localparam int ClW      = 17;
    localparam int ValW     = 16;
    localparam int DentW    = 15;
    localparam int ResW     = 32;
    localparam int ErrW     = 3;
    localparam int CmdW     = 3;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;
    localparam int LastW    = 12;
    localparam int BpcW     = 8;
    localparam int DpcW     = 13;

    // chain walk arms the loop detector after this many links
    localparam int LoopLinks = 10;

    // command codes
    localparam logic [CmdW-1:0] CMD_LOAD    = 3'd0;
    localparam logic [CmdW-1:0] CMD_READ    = 3'd1;
    localparam logic [CmdW-1:0] CMD_COUNT   = 3'd2;
    localparam logic [CmdW-1:0] CMD_CHAIN   = 3'd3;
    localparam logic [CmdW-1:0] CMD_ALLOC   = 3'd4;
    localparam logic [CmdW-1:0] CMD_FREE    = 3'd5;
    localparam logic [CmdW-1:0] CMD_CONVERT = 3'd6;

    // error codes
    localparam logic [ErrW-1:0] ERR_OK        = 3'd0;
    localparam logic [ErrW-1:0] ERR_FULL      = 3'd1;
    localparam logic [ErrW-1:0] ERR_BROKEN    = 3'd2;
    localparam logic [ErrW-1:0] ERR_ROOT      = 3'd3;
    localparam logic [ErrW-1:0] ERR_CHAIN_END = 3'd4;
    localparam logic [ErrW-1:0] ERR_RANGE     = 3'd5;
    localparam logic [ErrW-1:0] ERR_LOOP      = 3'd6;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_LAST = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_BPC  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_DPC  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_DSB  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_PSB  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_ROOT = 3'd5;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SET_ERR,
        OP_WR_LOAD,
        OP_RD_CUR,
        OP_RES_RD,
        OP_SCAN,
        OP_MUL,
        OP_POST,
        OP_CH_STEP,
        OP_RD_F,
        OP_F_INC,
        OP_AL_FOUND,
        OP_WR_LINK,
        OP_WALK,
        OP_WR_EOF,
        OP_FR_END,
        OP_FR_RD,
        OP_FR_STEP,
        OP_DIV,
        OP_CV_STEP,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op          op;
        logic [ErrW-1:0] err;
    } t_dp_cmd;

    typedef struct packed {
        logic [CmdW-1:0] cmd;
        logic            cl_neg;
        logic            cl_le0;
        logic            cur_in_tab;
        logic            cur_term;
        logic            cur_eof;
        logic            rd_term;
        logic            rd_eof;
        logic            rd_zero;
        logic            rd_loop;
        logic            rd_conv_bad;
        logic            steps_over;
        logic            f_past;
        logic            f_in_tab;
        logic            scan_done;
        logic            div_done;
        logic            i_zero;
        logic            out_busy;
    } t_dp_sts;

endpackage

// ===== rtl/core/fat_cluster_chain_engine_unit.sv =====
// Cluster chain engine for a FAT16-style table: one command per s_axis transaction,
// one result per command on m_axis. Commands take a data-dependent number of cycles,
// all paced by the single table RAM (one read or one write per cycle). Chain measure
// and free walk the chain link by link, allocate scans clusters for a free entry and
// then walks to the chain end, count disk reads every cluster from 2 up to last_cluster,
// and convert runs the divider before walking the chain. A new command is taken once
// the previous result sits in the output register. The table content is undefined
// after reset until loaded; there is no clearing pass.
module fat_cluster_chain_engine_unit import fcce_pkg::*; #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int ENTRY_WIDTH   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [47:0]         s_axis_tdata,  // cluster[16:0], entry_value[32:17], dir_entry[47:33]
    input  logic [2:0]          s_axis_tuser,  // cmd[2:0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [71:0]         m_axis_tdata   // result_value[31:0], error_code[34:32],
                                               // used_blocks[66:35], zero[71:67]
);

    t_dp_cmd         ctl;
    t_dp_sts         sts;
    logic [ResW-1:0] res, used;
    logic [ErrW-1:0] err;

    fcce_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid),
        .o_ready(s_axis_tready),
        .i_sts  (sts),
        .o_ctl  (ctl)
    );

    fcce_dp #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .ENTRY_WIDTH  (ENTRY_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (s_axis_tuser),
        .i_cl       (s_axis_tdata[16:0]),
        .i_val      (s_axis_tdata[32:17]),
        .i_dent     (s_axis_tdata[47:33]),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_valid    (m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_res      (res),
        .o_err      (err),
        .o_used     (used)
    );

    assign m_axis_tdata = {5'd0, used, err, res};

endmodule

// ===== rtl/core/fcce_ram.sv =====
module fcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/core/fcce_ctrl.sv =====
module fcce_ctrl import fcce_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_ctl
);

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_DISP    = 21'h000002,
        S_LOAD    = 21'h000004,
        S_RD      = 21'h000008,
        S_RD_WAIT = 21'h000010,
        S_SCAN    = 21'h000020,
        S_MUL     = 21'h000040,
        S_POST    = 21'h000080,
        S_CH_RD   = 21'h000100,
        S_CH_CK   = 21'h000200,
        S_AL_RD   = 21'h000400,
        S_AL_CK   = 21'h000800,
        S_AW_RD   = 21'h001000,
        S_AW_CK   = 21'h002000,
        S_AL_EOF  = 21'h004000,
        S_FR_TEST = 21'h008000,
        S_FR_CK   = 21'h010000,
        S_CV_DIV  = 21'h020000,
        S_CV_TEST = 21'h040000,
        S_CV_CK   = 21'h080000,
        S_FIN     = 21'h100000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and micro-op
    always_comb begin
        n_state = r_state;
        o_ctl   = '{op: OP_NONE, err: ERR_OK};
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.op = OP_ACCEPT;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                o_ctl.op = OP_SET_ERR;
                n_state  = S_FIN;
                unique case (i_sts.cmd)
                    CMD_LOAD, CMD_READ: begin
                        if (i_sts.cl_neg || !i_sts.cur_in_tab) begin
                            o_ctl.err = ERR_RANGE;
                        end else begin
                            o_ctl.op = OP_NONE;
                            n_state  = (i_sts.cmd == CMD_LOAD) ? S_LOAD : S_RD;
                        end
                    end
                    CMD_COUNT: begin
                        o_ctl.op = OP_NONE;
                        n_state  = S_SCAN;
                    end
                    CMD_CHAIN: begin
                        if (i_sts.cl_neg) begin
                            o_ctl.err = ERR_RANGE;
                        end else begin
                            o_ctl.op = OP_NONE;
                            n_state  = S_CH_RD;
                        end
                    end
                    CMD_ALLOC: begin
                        if (i_sts.cl_le0) begin
                            o_ctl.err = ERR_FULL;
                        end else begin
                            o_ctl.op = OP_NONE;
                            n_state  = S_AL_RD;
                        end
                    end
                    CMD_FREE: begin
                        if (i_sts.cl_le0) begin
                            o_ctl.err = ERR_ROOT;
                        end else begin
                            o_ctl.op = OP_NONE;
                            n_state  = S_FR_TEST;
                        end
                    end
                    CMD_CONVERT: begin
                        o_ctl.op = OP_NONE;
                        n_state  = S_CV_DIV;
                    end
                    default: begin
                        o_ctl.err = ERR_RANGE;
                    end
                endcase
            end
            S_LOAD: begin
                o_ctl.op = OP_WR_LOAD;
                n_state  = S_FIN;
            end
            S_RD: begin
                o_ctl.op = OP_RD_CUR;
                n_state  = S_RD_WAIT;
            end
            S_RD_WAIT: begin
                o_ctl.op = OP_RES_RD;
                n_state  = S_FIN;
            end
            S_SCAN: begin
                o_ctl.op = OP_SCAN;
                if (i_sts.scan_done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_ctl.op = OP_MUL;
                n_state  = S_POST;
            end
            S_POST: begin
                o_ctl.op = OP_POST;
                n_state  = S_FIN;
            end
            // chain measurement
            S_CH_RD: begin
                if (!i_sts.cur_in_tab) begin
                    o_ctl = '{op: OP_SET_ERR, err: ERR_RANGE};
                    n_state = S_FIN;
                end else begin
                    o_ctl.op = OP_RD_CUR;
                    n_state  = S_CH_CK;
                end
            end
            S_CH_CK: begin
                if (i_sts.rd_term) begin
                    n_state = S_MUL;
                end else if (i_sts.rd_loop || i_sts.steps_over) begin
                    o_ctl = '{op: OP_SET_ERR, err: ERR_LOOP};
                    n_state = S_FIN;
                end else begin
                    o_ctl.op = OP_CH_STEP;
                    n_state  = S_CH_RD;
                end
            end
            // allocate: free scan
            S_AL_RD: begin
                if (i_sts.f_past) begin
                    o_ctl = '{op: OP_SET_ERR, err: ERR_FULL};
                    n_state = S_FIN;
                end else if (!i_sts.f_in_tab) begin
                    o_ctl.op = OP_F_INC;
                end else begin
                    o_ctl.op = OP_RD_F;
                    n_state  = S_AL_CK;
                end
            end
            S_AL_CK: begin
                if (i_sts.rd_zero) begin
                    o_ctl.op = OP_AL_FOUND;
                    n_state  = i_sts.cur_eof ? S_AL_EOF : S_AW_RD;
                end else begin
                    o_ctl.op = OP_F_INC;
                    n_state  = S_AL_RD;
                end
            end
            // allocate: walk to chain end
            S_AW_RD: begin
                if (!i_sts.cur_in_tab) begin
                    o_ctl = '{op: OP_SET_ERR, err: ERR_RANGE};
                    n_state = S_FIN;
                end else begin
                    o_ctl.op = OP_RD_CUR;
                    n_state  = S_AW_CK;
                end
            end
            S_AW_CK: begin
                if (i_sts.rd_term) begin
                    if (!i_sts.rd_eof) begin
                        o_ctl = '{op: OP_SET_ERR, err: ERR_BROKEN};
                        n_state = S_FIN;
                    end else begin
                        o_ctl.op = OP_WR_LINK;
                        n_state  = S_AL_EOF;
                    end
                end else if (i_sts.steps_over) begin
                    o_ctl = '{op: OP_SET_ERR, err: ERR_LOOP};
                    n_state = S_FIN;
                end else begin
                    o_ctl.op = OP_WALK;
                    n_state  = S_AW_RD;
                end
            end
            S_AL_EOF: begin
                o_ctl.op = OP_WR_EOF;
                n_state  = S_FIN;
            end
            // free chain
            S_FR_TEST: begin
                if (i_sts.cur_term) begin
                    o_ctl.op = OP_FR_END;
                    n_state  = S_MUL;
                end else if (!i_sts.cur_in_tab) begin
                    o_ctl = '{op: OP_SET_ERR, err: ERR_RANGE};
                    n_state = S_MUL;
                end else begin
                    o_ctl.op = OP_FR_RD;
                    n_state  = S_FR_CK;
                end
            end
            S_FR_CK: begin
                o_ctl.op = OP_FR_STEP;
                n_state  = S_FR_TEST;
            end
            // convert
            S_CV_DIV: begin
                if (i_sts.div_done) begin
                    n_state = i_sts.cl_le0 ? S_MUL : S_CV_TEST;
                end else begin
                    o_ctl.op = OP_DIV;
                end
            end
            S_CV_TEST: begin
                if (i_sts.i_zero) begin
                    n_state = S_MUL;
                end else if (!i_sts.cur_in_tab) begin
                    o_ctl = '{op: OP_SET_ERR, err: ERR_RANGE};
                    n_state = S_FIN;
                end else begin
                    o_ctl.op = OP_RD_CUR;
                    n_state  = S_CV_CK;
                end
            end
            S_CV_CK: begin
                if (i_sts.rd_conv_bad) begin
                    o_ctl = '{op: OP_SET_ERR, err: ERR_RANGE};
                    n_state = S_FIN;
                end else begin
                    o_ctl.op = OP_CV_STEP;
                    n_state  = S_CV_TEST;
                end
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_ctl.op = OP_OUT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/fcce_dp.sv =====
module fcce_dp import fcce_pkg::*; #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int ENTRY_WIDTH   = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic [CmdW-1:0]     i_cmd,
    input  logic [ClW-1:0]      i_cl,
    input  logic [ValW-1:0]     i_val,
    input  logic [DentW-1:0]    i_dent,
    input  t_dp_cmd             i_ctl,
    output t_dp_sts             o_sts,
    output logic                o_valid,
    input  logic                i_out_ready,
    output logic [ResW-1:0]     o_res,
    output logic [ErrW-1:0]     o_err,
    output logic [ResW-1:0]     o_used
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int EW = ENTRY_WIDTH;
    localparam int CW = (ENTRY_WIDTH > 16) ? ENTRY_WIDTH : 16;
    localparam logic [EW-1:0] E_MAX  = {EW{1'b1}};
    localparam logic [EW-1:0] E_BAD  = E_MAX - EW'(8);
    localparam logic [EW-1:0] E_EOFL = E_MAX - EW'(7);
    localparam logic [32:0]   TE33   = 33'(TABLE_ENTRIES);

    // configuration
    logic [LastW-1:0] r_last;
    logic [BpcW-1:0]  r_bpc;
    logic [DpcW-1:0]  r_dpc;
    logic [31:0]      r_dsb, r_psb, r_root;

    // persistent state
    logic [15:0]      r_hint;
    logic [31:0]      r_used;

    // per-command working registers
    logic [CmdW-1:0]       r_cmd;
    logic signed [ClW-1:0] r_cl;
    logic [ValW-1:0]       r_val;
    logic [CW-1:0]         r_cur;
    logic [16:0]           r_f;
    logic [16:0]           r_links, r_steps, r_n;
    logic [EW-1:0]         r_old;
    logic [12:0]           r_cnt, r_scan;
    logic                  r_svld;
    logic [DentW-1:0]      r_q;
    logic [12:0]           r_rem;
    logic [3:0]            r_dcnt;
    logic signed [17:0]    r_mula;
    logic signed [26:0]    r_prod;
    logic [ResW-1:0]       r_res;
    logic [ErrW-1:0]       r_err;

    // output register
    logic                  r_o_valid;
    logic [ResW-1:0]       r_o_res, r_o_used;
    logic [ErrW-1:0]       r_o_err;

    // table memory
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_wa, ram_ra;
    logic [EW-1:0] ram_wd, rd;

    fcce_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(ram_wa),
        .i_wr_data(ram_wd),
        .i_rd_en  (ram_re),
        .i_rd_addr(ram_ra),
        .o_rd_data(rd)
    );

    logic              cl_le0, scan_issue;
    logic [DpcW-1:0]   dpc_eff;
    logic [12:0]       div_t;
    logic signed [17:0] mula_n;
    logic [32:0]       blk;
    logic [31:0]       cnt_total;

    assign cl_le0     = r_cl[ClW-1] || (r_cl == '0);
    assign scan_issue = (r_scan <= {1'b0, r_last}) && (33'(r_scan) < TE33);
    assign dpc_eff    = (r_dpc == '0) ? DpcW'(1) : r_dpc;
    assign div_t      = {r_rem[11:0], r_q[DentW-1]};
    assign blk        = 33'(r_prod) + {1'b0, r_root};
    assign cnt_total  = r_dsb - r_psb + 32'(r_prod);

    // status to controller
    always_comb begin
        o_sts.cmd         = r_cmd;
        o_sts.cl_neg      = r_cl[ClW-1];
        o_sts.cl_le0      = cl_le0;
        o_sts.cur_in_tab  = 33'(r_cur) < TE33;
        o_sts.cur_term    = (r_cur >= CW'(E_BAD)) || (r_cur == '0);
        o_sts.cur_eof     = r_cur >= CW'(E_EOFL);
        o_sts.rd_term     = (rd >= E_BAD) || (rd == '0);
        o_sts.rd_eof      = rd >= E_EOFL;
        o_sts.rd_zero     = rd == '0;
        o_sts.rd_loop     = rd == r_old;
        o_sts.rd_conv_bad = (rd >= E_BAD) || (rd == '0) || (33'(rd) > 33'(r_last));
        o_sts.steps_over  = (18'(r_steps) + 18'd1) > 18'(TABLE_ENTRIES);
        o_sts.f_past      = r_f > 17'(r_last);
        o_sts.f_in_tab    = 33'(r_f) < TE33;
        o_sts.scan_done   = !scan_issue && !r_svld;
        o_sts.div_done    = r_dcnt == '0;
        o_sts.i_zero      = r_q == '0;
        o_sts.out_busy    = r_o_valid && !i_out_ready;
    end

    // memory port steering
    always_comb begin
        ram_re = 1'b0;
        ram_ra = AW'(r_cur);
        ram_we = 1'b0;
        ram_wa = AW'(r_cur);
        ram_wd = EW'(r_val);
        case (i_ctl.op)
            OP_RD_CUR, OP_FR_RD: ram_re = 1'b1;
            OP_RD_F: begin
                ram_re = 1'b1;
                ram_ra = AW'(r_f);
            end
            OP_SCAN: begin
                ram_re = scan_issue;
                ram_ra = AW'(r_scan);
            end
            OP_WR_LOAD: ram_we = 1'b1;
            OP_WR_LINK: begin
                ram_we = 1'b1;
                ram_wd = EW'(r_f);
            end
            OP_WR_EOF: begin
                ram_we = 1'b1;
                ram_wa = AW'(r_f);
                ram_wd = E_MAX;
            end
            OP_FR_STEP: begin
                ram_we = 1'b1;
                ram_wd = '0;
            end
            default: ;
        endcase
    end

    // multiplier operand by command
    always_comb begin
        case (r_cmd)
            CMD_COUNT: mula_n = 18'(r_cnt);
            CMD_CHAIN: mula_n = 18'(r_links);
            CMD_FREE:  mula_n = 18'(r_n);
            default: begin
                if (cl_le0) begin
                    mula_n = 18'(r_q) - 18'(r_cl);
                end else begin
                    mula_n = 18'(r_cur[15:0]) - 18'd2;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '1;
            r_bpc     <= BpcW'(1);
            r_dpc     <= DpcW'(16);
            r_dsb     <= '0;
            r_psb     <= '0;
            r_root    <= '0;
            r_hint    <= 16'd2;
            r_used    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LAST: r_last <= i_cfg_data[LastW-1:0];
                    CFG_BPC:  r_bpc  <= i_cfg_data[BpcW-1:0];
                    CFG_DPC:  r_dpc  <= i_cfg_data[DpcW-1:0];
                    CFG_DSB:  r_dsb  <= i_cfg_data;
                    CFG_PSB:  r_psb  <= i_cfg_data;
                    CFG_ROOT: r_root <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            case (i_ctl.op)
                OP_AL_FOUND: r_hint <= 16'(r_f);
                OP_FR_RD: begin
                    if (33'(r_cur) < 33'(r_hint)) begin
                        r_hint <= 16'(r_cur);
                    end
                end
                OP_WR_EOF: r_used <= r_used + 32'(r_bpc);
                OP_POST: begin
                    if (r_cmd == CMD_COUNT) begin
                        r_used <= cnt_total;
                    end else if (r_cmd == CMD_FREE) begin
                        r_used <= r_used - 32'(r_prod);
                    end
                end
                OP_OUT: r_o_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            OP_ACCEPT: begin
                r_cmd   <= i_cmd;
                r_cl    <= i_cl;
                r_val   <= i_val;
                r_cur   <= CW'(i_cl[15:0]);
                r_f     <= (r_hint < 16'd2) ? 17'd2 : 17'(r_hint);
                r_links <= 17'd1;
                r_steps <= '0;
                r_n     <= '0;
                r_old   <= '0;
                r_cnt   <= '0;
                r_scan  <= 13'd2;
                r_svld  <= 1'b0;
                r_q     <= i_dent;
                r_rem   <= '0;
                r_dcnt  <= 4'(DentW);
                r_res   <= '0;
                r_err   <= ERR_OK;
            end
            OP_SET_ERR: r_err <= i_ctl.err;
            OP_RES_RD:  r_res <= 32'(rd);
            OP_SCAN: begin
                if (scan_issue) begin
                    r_scan <= r_scan + 13'd1;
                end
                r_svld <= scan_issue;
                if (r_svld && (rd != '0)) begin
                    r_cnt <= r_cnt + 13'd1;
                end
            end
            OP_MUL: begin
                r_mula <= mula_n;
                r_prod <= mula_n * $signed({1'b0, r_bpc});
            end
            OP_POST: begin
                case (r_cmd)
                    CMD_COUNT: r_res <= cnt_total;
                    CMD_CHAIN: r_res <= 32'(r_prod);
                    CMD_FREE:  r_res <= (r_err == ERR_RANGE) ? '0 : 32'(r_n);
                    default: begin
                        if (!cl_le0) begin
                            r_res <= r_dsb + 32'(r_prod);
                        end else if (blk >= {1'b0, r_dsb}) begin
                            r_err <= ERR_RANGE;
                        end else begin
                            r_res <= blk[31:0];
                        end
                    end
                endcase
            end
            OP_CH_STEP: begin
                r_steps <= r_steps + 17'd1;
                r_links <= r_links + 17'd1;
                if (r_links == 17'(LoopLinks)) begin
                    r_old <= rd;
                end
                r_cur <= CW'(rd);
            end
            OP_F_INC: r_f <= r_f + 17'd1;
            OP_WALK: begin
                r_steps <= r_steps + 17'd1;
                r_cur   <= CW'(rd);
            end
            OP_WR_EOF: r_res <= 32'(r_f);
            OP_FR_END: begin
                if (r_cur < CW'(E_EOFL)) begin
                    r_err <= ERR_CHAIN_END;
                end
            end
            OP_FR_STEP: begin
                r_cur <= CW'(rd);
                r_n   <= r_n + 17'd1;
            end
            OP_DIV: begin
                // restoring divide, one quotient bit per cycle
                r_dcnt <= r_dcnt - 4'd1;
                if (div_t >= dpc_eff) begin
                    r_rem <= div_t - dpc_eff;
                    r_q   <= {r_q[DentW-2:0], 1'b1};
                end else begin
                    r_rem <= div_t;
                    r_q   <= {r_q[DentW-2:0], 1'b0};
                end
            end
            OP_CV_STEP: begin
                r_cur <= CW'(rd);
                r_q   <= r_q - DentW'(1);
            end
            OP_OUT: begin
                r_o_res  <= r_res;
                r_o_err  <= r_err;
                r_o_used <= r_used;
            end
            default: ;
        endcase
    end

    assign o_valid = r_o_valid;
    assign o_res   = r_o_res;
    assign o_err   = r_o_err;
    assign o_used  = r_o_used;

endmodule

// ===== sim/fcce_checker.sv =====
`timescale 1ns / 1ps

// Watches the command and result streams, runs a shadow FAT engine and
// compares every result transaction with the oldest prediction.
module fat_chain_checker import fcce_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [47:0]         i_s_tdata,  // cluster[16:0], entry_value[32:17], dir_entry[47:33]
    input  logic [2:0]          i_s_tuser,  // cmd[2:0]
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [71:0]         i_m_tdata,  // result_value[31:0], error_code[34:32], used_blocks[66:35]
    output int                  o_fail_cnt,
    output int                  o_pending,
    output int                  o_checked,
    output int                  o_err_hits [8]
);

    localparam int unsigned TBL_N = 4096;
    localparam longint unsigned ENT_BAD = 64'hFFF7;
    localparam longint unsigned ENT_EOF_LOW = 64'hFFF8;
    localparam logic [15:0] ENT_EOF = 16'hFFFF;
    localparam longint unsigned M32 = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0]     value;
        logic [ErrW-1:0] err;
        logic [31:0]     used;
    } fat_result_t;

    // shadow engine state
    logic [15:0]     fat_tbl [TBL_N];
    logic [15:0]     free_hint;
    logic [31:0]     used_blk;
    logic [LastW-1:0] last_cl;
    logic [BpcW-1:0]  bpc;
    logic [DpcW-1:0]  dpc;
    logic [31:0]     data_start, part_start, root_start;

    fat_result_t results_due[$];

    // apply one command to the shadow engine and return its result
    task automatic predict_fat_result(input logic [2:0] cmd, input logic [16:0] cl_raw,
                                      input logic [15:0] val, input logic [14:0] dent,
                                      output fat_result_t r);
        longint cl;
        longint unsigned cur, nxt, links, old, steps, n, f, cnt, blk, mult, dpcv, bpcv, resv;
        logic [ErrW-1:0] err;
        bit found;
        cl = longint'($signed(cl_raw));
        resv = 0;
        err = ERR_OK;
        bpcv = bpc;
        nxt = 0;
        case (cmd)
            CMD_LOAD, CMD_READ: begin
                if (cl < 0 || cl >= TBL_N) err = ERR_RANGE;
                else if (cmd == CMD_LOAD) fat_tbl[cl] = val;
                else resv = fat_tbl[cl];
            end
            CMD_COUNT: begin
                cnt = 0;
                for (cur = 2; cur <= last_cl; cur++)
                    if (fat_tbl[cur] != 0) cnt++;
                resv = (longint'(data_start) - part_start + cnt * bpcv) & M32;
                used_blk = resv[31:0];
            end
            CMD_CHAIN: begin
                if (cl < 0) begin
                    err = ERR_RANGE;
                end else begin
                    cur = cl; links = 1; old = 0; steps = 0;
                    forever begin
                        if (cur >= TBL_N) begin err = ERR_RANGE; break; end
                        nxt = fat_tbl[cur];
                        if (nxt >= ENT_BAD || nxt == 0) break;
                        steps++;
                        if (old == nxt || steps > TBL_N) begin err = ERR_LOOP; break; end
                        // loop detector arms once the tenth link is passed
                        if (links == LoopLinks) old = nxt;
                        links++;
                        cur = nxt;
                    end
                    if (err == ERR_OK) resv = (links * bpcv) & M32;
                end
            end
            CMD_ALLOC: begin
                if (cl <= 0) begin
                    err = ERR_FULL;
                end else begin
                    f = (free_hint < 2) ? 2 : free_hint;
                    found = 0;
                    for (; f <= last_cl; f++)
                        if (f < TBL_N && fat_tbl[f] == 0) begin found = 1; break; end
                    if (!found) begin
                        err = ERR_FULL;
                    end else begin
                        free_hint = f[15:0];
                        cur = cl;
                        // end-of-chain cluster numbers are not linked
                        if (cur < ENT_EOF_LOW) begin
                            steps = 0;
                            forever begin
                                if (cur >= TBL_N) begin err = ERR_RANGE; break; end
                                nxt = fat_tbl[cur];
                                if (nxt >= ENT_BAD || nxt == 0) break;
                                steps++;
                                if (steps > TBL_N) begin err = ERR_LOOP; break; end
                                cur = nxt;
                            end
                            if (err == ERR_OK && nxt < ENT_EOF_LOW) err = ERR_BROKEN;
                            if (err == ERR_OK) fat_tbl[cur] = f[15:0];
                        end
                        if (err == ERR_OK) begin
                            fat_tbl[f] = ENT_EOF;
                            used_blk = used_blk + bpcv[31:0];
                            resv = f;
                        end
                    end
                end
            end
            CMD_FREE: begin
                if (cl <= 0) begin
                    err = ERR_ROOT;
                end else begin
                    cur = cl; n = 0;
                    while (cur < ENT_BAD && cur != 0) begin
                        if (cur >= TBL_N) begin err = ERR_RANGE; break; end
                        if (cur < free_hint) free_hint = cur[15:0];
                        nxt = fat_tbl[cur];
                        fat_tbl[cur] = 0;
                        cur = nxt;
                        n++;
                    end
                    if (err == ERR_OK && cur < ENT_EOF_LOW) err = ERR_CHAIN_END;
                    used_blk = used_blk - 32'(n * bpcv);
                    resv = (err == ERR_RANGE) ? 0 : n;
                end
            end
            CMD_CONVERT: begin
                dpcv = (dpc == 0) ? 1 : dpc;
                mult = dent / dpcv;
                if (cl <= 0) begin
                    blk = (longint'(-cl) + mult) * bpcv + root_start;
                    if (blk >= data_start) err = ERR_RANGE;
                    else resv = blk;
                end else begin
                    cur = cl;
                    for (n = mult; n > 0; n--) begin
                        if (cur >= TBL_N) begin err = ERR_RANGE; break; end
                        cur = fat_tbl[cur];
                        if (cur >= ENT_BAD || cur == 0 || cur > last_cl) begin
                            err = ERR_RANGE;
                            break;
                        end
                    end
                    if (err == ERR_OK) resv = ((cur - 2) * bpcv + data_start) & M32;
                end
            end
            default: err = ERR_RANGE;
        endcase
        r.value = resv[31:0];
        r.err = err;
        r.used = used_blk;
    endtask

    assign o_pending = results_due.size();

    always @(posedge i_clk) begin
        fat_result_t exp_r, act_r, new_r;
        if (!i_rst_n) begin
            free_hint <= 16'd2;
            used_blk <= '0;
            last_cl <= 12'd4095;
            bpc <= 8'd1;
            dpc <= 13'd16;
            data_start <= '0;
            part_start <= '0;
            root_start <= '0;
            o_fail_cnt <= 0;
            o_checked <= 0;
            for (int k = 0; k < 8; k++) o_err_hits[k] <= 0;
            results_due.delete();
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LAST: last_cl = i_cfg_data[LastW-1:0];
                    CFG_BPC:  bpc = i_cfg_data[BpcW-1:0];
                    CFG_DPC:  dpc = i_cfg_data[DpcW-1:0];
                    CFG_DSB:  data_start = i_cfg_data;
                    CFG_PSB:  part_start = i_cfg_data;
                    CFG_ROOT: root_start = i_cfg_data;
                    default: ;
                endcase
            end
            // result transaction: compare against oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                act_r.value = i_m_tdata[31:0];
                act_r.err = i_m_tdata[34:32];
                act_r.used = i_m_tdata[66:35];
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result value=%h err=%0d used=%h",
                             $time, act_r.value, act_r.err, act_r.used);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    exp_r = results_due.pop_front();
                    o_checked <= o_checked + 1;
                    o_err_hits[exp_r.err] <= o_err_hits[exp_r.err] + 1;
                    if (act_r.value !== exp_r.value)
                        $display("%0t: result_value expected %h actual %h",
                                 $time, exp_r.value, act_r.value);
                    if (act_r.err !== exp_r.err)
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, exp_r.err, act_r.err);
                    if (act_r.used !== exp_r.used)
                        $display("%0t: used_blocks expected %h actual %h",
                                 $time, exp_r.used, act_r.used);
                    if (act_r !== exp_r) o_fail_cnt <= o_fail_cnt + 1;
                end
            end
            // command transaction
            if (i_s_tvalid && i_s_tready) begin
                predict_fat_result(i_s_tuser, i_s_tdata[16:0], i_s_tdata[32:17],
                                   i_s_tdata[47:33], new_r);
                results_due.push_back(new_r);
            end
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import fcce_pkg::*;

    localparam logic [CmdW-1:0] CMD_UNKNOWN = 3'd7;
    localparam logic [15:0] ENT_EOF = 16'hFFFF;
    localparam logic [15:0] ENT_EOF_LOW = 16'hFFF8;
    localparam logic [15:0] ENT_BAD = 16'hFFF7;
    localparam int PHASE_ITEMS = 210;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [47:0]         s_axis_tdata = '0;  // cluster[16:0], entry_value[32:17], dir_entry[47:33]
    logic [2:0]          s_axis_tuser = '0;  // cmd[2:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [71:0]         m_axis_tdata;       // result_value[31:0], error_code[34:32], used_blocks[66:35]

    int fail_cnt, pending, checked;
    int err_hits [8];
    int items_sent = 0;
    int burst_left = 0;
    int last_cur = 4095;
    int dpc_cur = 16;
    bit long_stall_done = 0;

    fat_cluster_chain_engine_unit DUT (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
    );

    fat_chain_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tuser(s_axis_tuser),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .o_fail_cnt(fail_cnt), .o_pending(pending), .o_checked(checked),
        .o_err_hits(err_hits)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop
    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: ready stretches, random stalls, one long hold-off
    initial begin
        int n;
        int mode;
        @(posedge i_clk);
        wait (i_rst_n);
        forever begin
            mode = $urandom_range(0, 3);
            n = $urandom_range(5, 60);
            if (!long_stall_done && items_sent > 4600) begin
                long_stall_done = 1;
                repeat (400) @(posedge i_clk) m_axis_tready <= 1'b0;
            end else if (mode == 0) begin
                repeat (n) @(posedge i_clk) m_axis_tready <= 1'b1;
            end else begin
                repeat (n) @(posedge i_clk) m_axis_tready <= ($urandom_range(0, 99) < 55);
            end
        end
    end

    // offer one command and hold it until taken; bursts with idle gaps
    task automatic send_cmd(input logic [2:0] cmd, input logic signed [16:0] cl,
                            input logic [15:0] val = '0, input logic [14:0] dent = '0);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {dent, val, cl};
        s_axis_tuser <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
        burst_left--;
        if (burst_left == 0) s_axis_tvalid <= 1'b0;
    endtask

    // stop offering and wait until every command has answered
    task automatic drain();
        if (burst_left != 0) begin
            burst_left = 0;
            s_axis_tvalid <= 1'b0;
        end
        do @(posedge i_clk); while (checked != items_sent);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_config(input int last, input int bpcv, input int dpcv,
                              input logic [31:0] dsb, input logic [31:0] psb,
                              input logic [31:0] root);
        logic [CfgDataW-1:0] vals [6];
        logic [CfgIdxW-1:0] idxs [6];
        drain();
        vals = '{last, bpcv, dpcv, dsb, psb, root};
        idxs = '{CFG_LAST, CFG_BPC, CFG_DPC, CFG_DSB, CFG_PSB, CFG_ROOT};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idxs[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        last_cur = last;
        dpc_cur = dpcv;
    endtask

    function automatic logic signed [16:0] rand_cluster();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, last_cur);
        if (r < 90) return $urandom_range(2, 4095);
        if (r < 95) return -$signed($urandom_range(1, 255));
        return $signed($urandom_range(0, 65535 + 255)) - 255;
    endfunction

    function automatic logic [15:0] rand_entry();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(2, last_cur);
        if (r < 60) return $urandom_range(ENT_BAD, ENT_EOF);
        if (r < 80) return 16'h0000;
        return $urandom_range(0, 65535);
    endfunction

    // keep divider walks short unless a cluster holds many entries
    function automatic logic [14:0] rand_dent();
        if (dpc_cur >= 256) return $urandom_range(0, 32767);
        return $urandom_range(0, 63);
    endfunction

    function automatic logic [2:0] rand_cmd();
        logic [2:0] ops [6];
        int r;
        ops = '{CMD_LOAD, CMD_READ, CMD_CHAIN, CMD_ALLOC, CMD_FREE, CMD_CONVERT};
        r = $urandom_range(0, 99);
        if (r < 2) return CMD_COUNT;
        if (r < 3) return CMD_UNKNOWN;
        return ops[$urandom_range(0, 5)];
    endfunction

    // build a linked chain, then work on its head
    task automatic chain_sequence();
        int k, nops, mult, d;
        logic [15:0] cls [16];
        logic [15:0] term;
        logic [2:0] ops [5];
        logic [2:0] op;
        ops = '{CMD_CHAIN, CMD_ALLOC, CMD_CONVERT, CMD_FREE, CMD_READ};
        k = $urandom_range(1, 14);
        for (int j = 0; j < k; j++) cls[j] = $urandom_range(2, last_cur);
        case ($urandom_range(0, 9))
            0: term = ENT_BAD;
            1: term = 16'h0000;
            default: term = $urandom_range(ENT_EOF_LOW, ENT_EOF);
        endcase
        for (int j = 0; j < k; j++)
            send_cmd(CMD_LOAD, cls[j], (j == k - 1) ? term : cls[j + 1], rand_dent());
        nops = $urandom_range(1, 4);
        for (int j = 0; j < nops; j++) begin
            op = ops[$urandom_range(0, 4)];
            mult = $urandom_range(0, k + 1);
            d = mult * dpc_cur + $urandom_range(0, dpc_cur - 1);
            if (d > 32767) d = $urandom_range(0, 32767);
            send_cmd(op, cls[0], rand_entry(), d);
        end
    endtask

    task automatic random_phase();
        int start;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) < 7) chain_sequence();
            else send_cmd(rand_cmd(), rand_cluster(), rand_entry(), rand_dent());
        end
    endtask

    // stimulus
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        set_config(4095, 1, 16, 0, 0, 0);
        // every table entry gets a defined value, mostly free
        for (int c = 0; c < 4096; c++)
            send_cmd(CMD_LOAD, c, ($urandom_range(0, 99) < 12) ? rand_entry() : 16'h0,
                     $urandom_range(0, 32767));

        // directed corner cases
        send_cmd(CMD_LOAD, 100, 16'd101);
        send_cmd(CMD_LOAD, 101, ENT_EOF);
        send_cmd(CMD_READ, 100);
        send_cmd(CMD_CHAIN, 100);
        send_cmd(CMD_ALLOC, 100);
        send_cmd(CMD_CONVERT, 100, 16'h0, 15'd16);
        send_cmd(CMD_CONVERT, 100, 16'h0, 15'h7FFF);
        send_cmd(CMD_CONVERT, -255, 16'h0, 15'h7FFF);
        send_cmd(CMD_CONVERT, 0);
        send_cmd(CMD_FREE, 100);
        send_cmd(CMD_ALLOC, 0);
        send_cmd(CMD_FREE, 0);
        send_cmd(CMD_FREE, -255);
        send_cmd(CMD_LOAD, 4096, 16'hFFFF);
        send_cmd(CMD_READ, -1);
        send_cmd(CMD_READ, 65535);
        send_cmd(CMD_UNKNOWN, 5);
        send_cmd(CMD_COUNT, 0);
        // two-cluster ring trips the loop detector
        send_cmd(CMD_LOAD, 200, 16'd201);
        send_cmd(CMD_LOAD, 201, 16'd200);
        send_cmd(CMD_CHAIN, 200);
        // chain ending on a bad cluster
        send_cmd(CMD_LOAD, 300, ENT_BAD);
        send_cmd(CMD_CHAIN, 300);
        send_cmd(CMD_FREE, 300);
        // chain ending on a free cluster cannot be extended
        send_cmd(CMD_LOAD, 301, 16'd302);
        send_cmd(CMD_LOAD, 302, 16'h0);
        send_cmd(CMD_ALLOC, 301);
        send_cmd(CMD_ALLOC, 65528);

        random_phase();
        set_config(255, 128, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FF00);
        random_phase();
        set_config(2, 3, 4096, 1000, 2000, 5);
        random_phase();
        set_config($urandom_range(3, 1023), $urandom_range(1, 128), $urandom_range(1, 4096),
                   $urandom, $urandom, $urandom);
        random_phase();
        set_config(4095, 128, 4096, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_0000);
        random_phase();
        set_config($urandom_range(2, 4095), $urandom_range(1, 128), $urandom_range(1, 4096),
                   $urandom, $urandom, $urandom);
        random_phase();

        drain();
        repeat (50) @(posedge i_clk);
        $display("Sent %0d commands over 6 register settings, %0d results checked.",
                 items_sent, checked);
        $display("Error codes seen: ok %0d full %0d broken %0d root %0d end %0d range %0d loop %0d",
                 err_hits[0], err_hits[1], err_hits[2], err_hits[3], err_hits[4],
                 err_hits[5], err_hits[6]);
        if (fail_cnt == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/fcce_pkg.sv
rtl/core/fcce_ram.sv
rtl/core/fcce_ctrl.sv
rtl/core/fcce_dp.sv
rtl/core/fat_cluster_chain_engine_unit.sv
sim/fcce_checker.sv
sim/testbench.sv
